>>> rtl/lcr_pkg.sv
`default_nettype none

package lcr_pkg;

	// Item command codes.
	typedef enum logic [1:0] {
		CMD_BYTE = 2'd0,
		CMD_TICK = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_END         = 3'd0,
		REG_FRAME       = 3'd1,
		REG_CONTROL     = 3'd2,
		REG_POWER_VAR   = 3'd3,
		REG_ENABLE_VAR  = 3'd4,
		REG_TIMEOUT_VAR = 3'd5
	} reg_idx_t;

	// Status carried with every result item.
	typedef struct packed {
		logic        idle_request;
		logic        frame_swapped;
		logic [15:0] power_duration;
		logic        idle_enabled;
		logic [15:0] idle_timeout;
		logic        parser_busy;
	} status_t;

	localparam logic [7:0]  IDLE_CMD          = 8'd0;
	localparam logic [1:0]  ARG_SLOTS         = 2'd3;
	localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
	localparam logic [15:0] POWER_RESET       = 16'd1000;
	localparam logic [15:0] TIMEOUT_RESET     = 16'd4000;
	localparam logic [7:0]  END_RESET         = 8'd255;
	localparam logic [7:0]  FRAME_RESET       = 8'd1;
	localparam logic [7:0]  CONTROL_RESET     = 8'd2;
	localparam logic [7:0]  POWER_VAR_RESET   = 8'd0;
	localparam logic [7:0]  ENABLE_VAR_RESET  = 8'd1;
	localparam logic [7:0]  TIMEOUT_VAR_RESET = 8'd2;

endpackage

`default_nettype wire

>>> rtl/lcr_frame_store.sv
`default_nettype none

module lcr_frame_store #(
	parameter int FRAME_BYTES = 128,
	parameter int AW = $clog2(2 * FRAME_BYTES),
	parameter int CW = $clog2(FRAME_BYTES + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_accept,
	input  wire logic          wr_en,
	input  wire logic          wr_bank,
	input  wire logic [CW-1:0] wr_idx,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_req,
	input  wire logic          rd_bank,
	input  wire logic [6:0]    rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0]    mem [2 * FRAME_BYTES];
	logic [7:0]    mem_q;
	logic          hit_q;
	logic [CW-1:0] fill0_q;
	logic [CW-1:0] fill1_q;
	logic [CW-1:0] rd_fill;
	logic [AW-1:0] wr_ptr;
	logic [AW-1:0] rd_ptr;
	logic          rd_hit;

	// Bank base plus offset; the back bank is written, the front bank is read.
	assign wr_ptr = (wr_bank ? AW'(FRAME_BYTES) : '0) + AW'(wr_idx);
	assign rd_ptr = (rd_bank ? AW'(FRAME_BYTES) : '0) + AW'(rd_addr);

	// A bank is always filled from entry zero upward, so its written entries form a
	// prefix. Entries at or above the fill count read as zero; the memory has no reset.
	assign rd_fill = rd_bank ? fill1_q : fill0_q;
	assign rd_hit  = rd_req && (32'(rd_addr) < FRAME_BYTES) && (32'(rd_addr) < 32'(rd_fill));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill0_q <= '0;
			fill1_q <= '0;
		end else if (wr_en) begin
			if (!wr_bank && wr_idx >= fill0_q) begin
				fill0_q <= wr_idx + CW'(1);
			end
			if (wr_bank && wr_idx >= fill1_q) begin
				fill1_q <= wr_idx + CW'(1);
			end
		end
	end

	// Memory write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr] <= wr_data;
		end
	end

	// Memory read port with registered data.
	always_ff @(posedge clk) begin
		if (rd_req) begin
			mem_q <= mem[rd_ptr];
		end
	end

	// The hit flag follows every item so that non-read items return zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (item_accept) begin
			hit_q <= rd_hit;
		end
	end

	assign rd_data = hit_q ? mem_q : 8'd0;

	a_fill0_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill0_q) <= FRAME_BYTES) else $error("bank 0 fill count out of range");

	a_fill1_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill1_q) <= FRAME_BYTES) else $error("bank 1 fill count out of range");

endmodule

`default_nettype wire

>>> rtl/lcr_parser.sv
`default_nettype none

module lcr_parser #(
	parameter int FRAME_BYTES = 128,
	parameter int CW = $clog2(FRAME_BYTES + 1)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_write,
	input  wire logic [2:0]      cfg_index,
	input  wire logic [7:0]      cfg_data,
	input  wire logic            item_accept,
	input  wire logic [1:0]      command,
	input  wire logic [7:0]      data_byte,
	output lcr_pkg::status_t     status_next,
	output logic                 front_bank,
	output logic                 wr_en,
	output logic      [CW-1:0]   wr_idx
);

	import lcr_pkg::*;

	logic [7:0]    end_q, frame_q, control_q, pvar_q, evar_q, tvar_q;
	logic [7:0]    cur_q, cur_d;
	logic [CW-1:0] fcnt_q, fcnt_d;
	logic [1:0]    acnt_q, acnt_d;
	logic [7:0]    arg_q [3];
	logic          arg_we;
	logic          front_q, front_d;
	logic [15:0]   power_q, power_d;
	logic          en_q, en_d;
	logic [15:0]   tmo_q, tmo_d;
	logic [15:0]   cnt_q, cnt_d;
	logic          act_q, act_d;
	logic [15:0]   cnt_inc;
	logic [15:0]   ctl_value;
	logic          swapped;
	logic          idle_req;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q     <= END_RESET;
			frame_q   <= FRAME_RESET;
			control_q <= CONTROL_RESET;
			pvar_q    <= POWER_VAR_RESET;
			evar_q    <= ENABLE_VAR_RESET;
			tvar_q    <= TIMEOUT_VAR_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_END:         end_q     <= cfg_data;
				REG_FRAME:       frame_q   <= cfg_data;
				REG_CONTROL:     control_q <= cfg_data;
				REG_POWER_VAR:   pvar_q    <= cfg_data;
				REG_ENABLE_VAR:  evar_q    <= cfg_data;
				REG_TIMEOUT_VAR: tvar_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cnt_inc   = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 16'd1;
	assign ctl_value = {arg_q[2], arg_q[1]};

	// Command parser and idle timer next state.
	always_comb begin
		cur_d    = cur_q;
		fcnt_d   = fcnt_q;
		acnt_d   = acnt_q;
		front_d  = front_q;
		power_d  = power_q;
		en_d     = en_q;
		tmo_d    = tmo_q;
		cnt_d    = cnt_q;
		act_d    = act_q;
		arg_we   = 1'b0;
		wr_en    = 1'b0;
		swapped  = 1'b0;
		idle_req = 1'b0;
		if (item_accept) begin
			unique case (cmd_t'(command))
				CMD_BYTE: begin
					act_d = 1'b1;
					cnt_d = '0;
					priority if (data_byte == end_q) begin
						// The end byte dispatches a pending command.
						if (cur_q != IDLE_CMD) begin
							cur_d = IDLE_CMD;
							priority if (cur_q == frame_q) begin
								front_d = ~front_q;
								swapped = 1'b1;
							end else if (cur_q == control_q) begin
								priority if (arg_q[0] == pvar_q) begin
									power_d = ctl_value;
								end else if (arg_q[0] == evar_q) begin
									en_d = |ctl_value;
								end else if (arg_q[0] == tvar_q) begin
									tmo_d = ctl_value;
								end else begin
									power_d = power_q;
								end
							end else begin
								swapped = 1'b0;
							end
						end
					end else if (cur_q == IDLE_CMD) begin
						cur_d  = data_byte;
						fcnt_d = '0;
						acnt_d = '0;
					end else if (cur_q == frame_q) begin
						if (fcnt_q < CW'(FRAME_BYTES)) begin
							wr_en  = 1'b1;
							fcnt_d = fcnt_q + CW'(1);
						end
					end else if (cur_q == control_q) begin
						if (acnt_q < ARG_SLOTS) begin
							arg_we = 1'b1;
							acnt_d = acnt_q + 2'd1;
						end
					end else begin
						// An unknown command is abandoned on its next byte.
						cur_d = IDLE_CMD;
					end
				end
				CMD_TICK: begin
					if (cnt_inc > tmo_q && en_q && act_q) begin
						cnt_d    = '0;
						act_d    = 1'b0;
						idle_req = 1'b1;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				default: ;
			endcase
		end
	end

	// Parser and settings state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= IDLE_CMD;
			fcnt_q  <= '0;
			acnt_q  <= '0;
			front_q <= 1'b0;
			power_q <= POWER_RESET;
			en_q    <= 1'b1;
			tmo_q   <= TIMEOUT_RESET;
			cnt_q   <= '0;
			act_q   <= 1'b0;
		end else begin
			cur_q   <= cur_d;
			fcnt_q  <= fcnt_d;
			acnt_q  <= acnt_d;
			front_q <= front_d;
			power_q <= power_d;
			en_q    <= en_d;
			tmo_q   <= tmo_d;
			cnt_q   <= cnt_d;
			act_q   <= act_d;
		end
	end

	// Argument bytes of a control command.
	always_ff @(posedge clk) begin
		if (arg_we) begin
			arg_q[acnt_q] <= data_byte;
		end
	end

	assign front_bank = front_q;
	assign wr_idx     = fcnt_q;

	always_comb begin
		status_next.idle_request   = idle_req;
		status_next.frame_swapped  = swapped;
		status_next.power_duration = power_d;
		status_next.idle_enabled   = en_d;
		status_next.idle_timeout   = tmo_d;
		status_next.parser_busy    = (cur_d != IDLE_CMD);
	end

	a_fcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fcnt_q) <= FRAME_BYTES) else $error("frame count beyond bank size");

	a_acnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acnt_q <= ARG_SLOTS) else $error("argument count beyond three");

	a_swap_idle: assert property (@(posedge clk) disable iff (!arst_n)
		swapped |=> (cur_q == IDLE_CMD && front_q != $past(front_q)))
		else $error("bank swap without return to idle");

endmodule

`default_nettype wire

>>> rtl/led_frame_command_receiver.sv
`default_nettype none

// Command byte receiver for an LED frame buffer. One item is accepted per clock
// cycle while in_stall is low; each gives one result through the read stage, which
// holds the synchronous frame memory read, and then the output register. Parsing,
// settings and the idle timer update in the cycle of acceptance, frame bytes are
// written into the back bank of a double-banked memory of 2*FRAME_BYTES bytes, and
// reads come from the front bank. A fill count per bank makes never-written bytes
// read as zero, so the block is ready straight out of reset with no clearing pass.
// Input stall rises only while both the read stage and the output register are
// full and the output is stalled.
module led_frame_command_receiver #(
	parameter int FRAME_BYTES = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  data_byte,
	input  wire logic [6:0]  read_address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  read_data,
	output logic             idle_request,
	output logic             frame_swapped,
	output logic      [15:0] power_duration,
	output logic             idle_enabled,
	output logic      [15:0] idle_timeout,
	output logic             parser_busy
);

	import lcr_pkg::*;

	localparam int CW = $clog2(FRAME_BYTES + 1);

	logic          in_accept;
	logic          rd_req;
	status_t       status_next;
	logic          front_bank;
	logic          wr_en;
	logic [CW-1:0] wr_idx;
	logic [7:0]    rd_data;
	logic          valid_s1;
	status_t       status_s1;
	logic          s1_adv;
	logic          out_valid_q;
	status_t       status_q;
	logic [7:0]    read_data_q;

	assign s1_adv    = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !s1_adv;
	assign in_accept = in_valid && !in_stall;
	assign rd_req    = in_accept && (cmd_t'(command) == CMD_READ);

	lcr_parser #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_accept (in_accept),
		.command     (command),
		.data_byte   (data_byte),
		.status_next (status_next),
		.front_bank  (front_bank),
		.wr_en       (wr_en),
		.wr_idx      (wr_idx)
	);

	lcr_frame_store #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_accept (in_accept),
		.wr_en       (wr_en),
		.wr_bank     (~front_bank),
		.wr_idx      (wr_idx),
		.wr_data     (data_byte),
		.rd_req      (rd_req),
		.rd_bank     (front_bank),
		.rd_addr     (read_address),
		.rd_data     (rd_data)
	);

	// Read stage: status waits here while the frame memory read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			status_s1 <= status_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			status_q    <= status_s1;
			read_data_q <= rd_data;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = read_data_q;
	assign idle_request   = status_q.idle_request;
	assign frame_swapped  = status_q.frame_swapped;
	assign power_duration = status_q.power_duration;
	assign idle_enabled   = status_q.idle_enabled;
	assign idle_timeout   = status_q.idle_timeout;
	assign parser_busy    = status_q.parser_busy;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(status_s1)))
		else $error("read stage item lost while blocked");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> (out_valid_q && status_q == $past(status_s1)))
		else $error("read stage item not moved to output");

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import lcr_pkg::*;

	localparam int FRAME_BYTES = 128;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;

	// One result item: the read byte and the status that travels with it.
	typedef struct packed {
		logic [7:0] read_data;
		status_t    status;
	} result_t;

	// Tracks the receiver's parser, frame banks, settings and idle timer, and
	// keeps the results still owed by the block in order.
	class cmd_result_board;
		logic [7:0]  code_end, code_frame, code_control;
		logic [7:0]  var_power, var_enable, var_timeout;
		logic [7:0]  active_cmd;
		int          fill_count;
		int          arg_index;
		logic [7:0]  arg_mem [3];
		bit          arg_valid [3];
		logic [7:0]  bank_mem [2*FRAME_BYTES];
		bit          shown_bank;
		logic [15:0] power_now, timeout_now, tick_count;
		bit          enable_now, seen_byte;
		result_t     status_due [$];
		int          errors;

		function new();
			code_end = END_RESET;
			code_frame = FRAME_RESET;
			code_control = CONTROL_RESET;
			var_power = POWER_VAR_RESET;
			var_enable = ENABLE_VAR_RESET;
			var_timeout = TIMEOUT_VAR_RESET;
			active_cmd = IDLE_CMD;
			fill_count = 0;
			arg_index = 0;
			foreach (arg_valid[i]) arg_valid[i] = 1'b0;
			foreach (bank_mem[i]) bank_mem[i] = 8'h00;
			shown_bank = 1'b0;
			power_now = POWER_RESET;
			enable_now = 1'b1;
			timeout_now = TIMEOUT_RESET;
			tick_count = '0;
			seen_byte = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [7:0] val);
			case (idx)
				REG_END:         code_end = val;
				REG_FRAME:       code_frame = val;
				REG_CONTROL:     code_control = val;
				REG_POWER_VAR:   var_power = val;
				REG_ENABLE_VAR:  var_enable = val;
				REG_TIMEOUT_VAR: var_timeout = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return status_due.size();
		endfunction

		// True while an end byte would dispatch a control command that reads an
		// argument byte never written since reset.
		function bit end_is_unsafe();
			return active_cmd != IDLE_CMD && active_cmd != code_frame &&
				active_cmd == code_control &&
				!(arg_valid[0] && arg_valid[1] && arg_valid[2]);
		endfunction

		// Parse one received byte; returns 1 when it swapped the banks.
		function bit parse_byte(logic [7:0] b);
			logic [15:0] word;
			bit swapped;
			swapped = 1'b0;
			seen_byte = 1'b1;
			tick_count = '0;
			if (b == code_end) begin
				if (active_cmd != IDLE_CMD) begin
					if (active_cmd == code_frame) begin
						shown_bank = ~shown_bank;
						swapped = 1'b1;
					end else if (active_cmd == code_control) begin
						word = {arg_mem[2], arg_mem[1]};
						if (arg_mem[0] == var_power)
							power_now = word;
						else if (arg_mem[0] == var_enable)
							enable_now = (word != 16'd0);
						else if (arg_mem[0] == var_timeout)
							timeout_now = word;
					end
					active_cmd = IDLE_CMD;
				end
			end else if (active_cmd == IDLE_CMD) begin
				active_cmd = b;
				fill_count = 0;
				arg_index = 0;
			end else if (active_cmd == code_frame) begin
				if (fill_count < FRAME_BYTES) begin
					bank_mem[{~shown_bank, 7'(fill_count)}] = b;
					fill_count++;
				end
			end else if (active_cmd == code_control) begin
				if (arg_index < int'(ARG_SLOTS)) begin
					arg_mem[arg_index] = b;
					arg_valid[arg_index] = 1'b1;
					arg_index++;
				end
			end else begin
				// Unknown command: this byte abandons it.
				active_cmd = IDLE_CMD;
			end
			return swapped;
		endfunction

		// Advance the idle timer on a loop tick; returns 1 on an idle request.
		function bit advance_idle_timer();
			if (tick_count != COUNT_MAX)
				tick_count++;
			if (tick_count > timeout_now && enable_now && seen_byte) begin
				tick_count = '0;
				seen_byte = 1'b0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_item(cmd_t cmd, logic [7:0] b, logic [6:0] addr);
			result_t r;
			r = '0;
			case (cmd)
				CMD_BYTE: r.status.frame_swapped = parse_byte(b);
				CMD_TICK: r.status.idle_request = advance_idle_timer();
				CMD_READ: r.read_data = bank_mem[{shown_bank, addr}];
				default: ;
			endcase
			r.status.power_duration = power_now;
			r.status.idle_enabled = enable_now;
			r.status.idle_timeout = timeout_now;
			r.status.parser_busy = (active_cmd != IDLE_CMD);
			status_due.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, name, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (status_due.size() == 0) begin
				errors++;
				$display("%0t: result with no item waiting, expected none, actual %0h",
					$time, got);
				return;
			end
			want = status_due.pop_front();
			compare_field("read_data", 16'(want.read_data), 16'(got.read_data));
			compare_field("idle_request", 16'(want.status.idle_request),
				16'(got.status.idle_request));
			compare_field("frame_swapped", 16'(want.status.frame_swapped),
				16'(got.status.frame_swapped));
			compare_field("power_duration", want.status.power_duration,
				got.status.power_duration);
			compare_field("idle_enabled", 16'(want.status.idle_enabled),
				16'(got.status.idle_enabled));
			compare_field("idle_timeout", want.status.idle_timeout, got.status.idle_timeout);
			compare_field("parser_busy", 16'(want.status.parser_busy),
				16'(got.status.parser_busy));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  command = '0;
	logic [7:0]  data_byte = '0;
	logic [6:0]  read_address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  read_data;
	logic        idle_request;
	logic        frame_swapped;
	logic [15:0] power_duration;
	logic        idle_enabled;
	logic [15:0] idle_timeout;
	logic        parser_busy;

	cmd_result_board sb;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	led_frame_command_receiver #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_top (
		.*
	);

	always #6 clk = ~clk;

	// Receiver side: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Every accepted result is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(result_t'{read_data, status_t'{idle_request, frame_swapped,
				power_duration, idle_enabled, idle_timeout, parser_busy}});
	end

	// Give up when nothing moves on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles > QUIET_LIMIT) begin
			$display("led_frame_command_receiver test failed");
			$finish;
		end
	end

	// Offer one item after idle cycles drawn one at a time, and note it once accepted.
	task automatic send_item(cmd_t cmd, logic [7:0] b, logic [6:0] addr);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		data_byte <= b;
		read_address <= addr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(cmd, b, addr);
		items_sent++;
	endtask

	task automatic send_byte(logic [7:0] b);
		// Never dispatch a control command whose arguments were never written.
		if (b == sb.code_end && sb.end_is_unsafe())
			b = b + 8'd1;
		send_item(CMD_BYTE, b, 7'($urandom));
	endtask

	task automatic send_tick();
		send_item(CMD_TICK, 8'($urandom), 7'($urandom));
	endtask

	task automatic send_read(logic [6:0] addr);
		send_item(CMD_READ, 8'($urandom), addr);
	endtask

	// Bring the parser back to idle before a well-formed command.
	task automatic flush_command();
		while (sb.active_cmd != IDLE_CMD) begin
			if (sb.end_is_unsafe())
				send_byte(~sb.code_end);
			else
				send_byte(sb.code_end);
		end
	endtask

	task automatic send_frame(int len);
		logic [7:0] d;
		flush_command();
		send_byte(sb.code_frame);
		repeat (len) begin
			d = 8'($urandom);
			if (d == sb.code_end)
				d = ~d;
			send_byte(d);
		end
		send_byte(sb.code_end);
	endtask

	// A control command with nargs argument bytes; a fourth one is extra.
	task automatic send_control(logic [7:0] var_code, logic [15:0] word, int nargs);
		flush_command();
		send_byte(sb.code_control);
		send_byte(var_code);
		if (nargs > 1)
			send_byte(word[7:0]);
		if (nargs > 2)
			send_byte(word[15:8]);
		if (nargs > 3)
			send_byte(8'($urandom));
		send_byte(sb.code_end);
	endtask

	// Stop offering and wait until every result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [7:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [7:0] e, f, c, pv, ev, tv);
		drain();
		write_reg(REG_END, e);
		write_reg(REG_FRAME, f);
		write_reg(REG_CONTROL, c);
		write_reg(REG_POWER_VAR, pv);
		write_reg(REG_ENABLE_VAR, ev);
		write_reg(REG_TIMEOUT_VAR, tv);
	endtask

	// Mostly well-formed commands with random content, plus ticks, reads and noise.
	task automatic run_random(int count);
		int stop_at, pick, nargs;
		logic [7:0] var_code;
		logic [15:0] word;
		cmd_t noise_cmd;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_frame($urandom_range(0, 12));
			end else if (pick < 65) begin
				pick = $urandom_range(0, 9);
				var_code = (pick < 3) ? sb.var_power : (pick < 6) ? sb.var_enable :
					(pick < 9) ? sb.var_timeout : 8'($urandom);
				word = 16'($urandom);
				if (var_code == sb.var_timeout && $urandom_range(0, 4) != 0)
					word = 16'($urandom_range(0, 10));
				if (var_code == sb.var_enable && $urandom_range(0, 3) == 0)
					word = '0;
				case ($urandom_range(0, 9))
					0: nargs = 1;
					1: nargs = 2;
					2: nargs = 4;
					default: nargs = 3;
				endcase
				send_control(var_code, word, nargs);
			end else if (pick < 78) begin
				repeat ($urandom_range(1, 12)) send_tick();
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 3))
					send_read(($urandom_range(0, 3) == 0) ? 7'($urandom) :
						7'($urandom_range(0, 15)));
			end else begin
				repeat ($urandom_range(1, 5)) begin
					noise_cmd = cmd_t'($urandom_range(0, 3));
					if (noise_cmd == CMD_BYTE)
						send_byte(8'($urandom));
					else
						send_item(noise_cmd, 8'($urandom), 7'($urandom));
				end
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset settings.
		set_config(END_RESET, FRAME_RESET, CONTROL_RESET, POWER_VAR_RESET,
			ENABLE_VAR_RESET, TIMEOUT_VAR_RESET);
		send_read(7'd127);
		send_byte(IDLE_CMD);
		send_byte(sb.code_end);
		send_byte(sb.code_frame);
		send_byte(8'h00);
		send_byte(8'hFE);
		send_byte(sb.code_end);
		send_read(7'd0);
		send_read(7'd1);
		send_control(sb.var_timeout, 16'd0, 4);
		send_tick();
		send_tick();
		send_control(sb.var_power, 16'd0, 3);
		// A short command keeps the value bytes of the last one.
		send_control(sb.var_enable, 16'd0, 1);
		send_byte(8'h55);
		send_byte(8'h10);
		send_item(CMD_NONE, 8'($urandom), 7'($urandom));

		// Frame code equal to control code: the frame command wins.
		set_config(8'h00, 8'h07, 8'h07, 8'h09, 8'h09, 8'h09);
		send_byte(8'h07);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_read(7'd0);

		// Equal variable codes: power wins over enable, enable over timeout.
		set_config(8'h00, 8'h07, 8'h08, 8'h09, 8'h09, 8'h09);
		send_control(8'h09, 16'hFFFF, 3);
		set_config(8'h00, 8'h07, 8'h08, 8'h0A, 8'h09, 8'h09);
		send_control(8'h09, 16'h0101, 3);

		// Random phases with different settings and idling.
		set_config(END_RESET, FRAME_RESET, CONTROL_RESET, POWER_VAR_RESET,
			ENABLE_VAR_RESET, TIMEOUT_VAR_RESET);
		run_random(45);

		set_config(8'h00, 8'hFF, 8'h01, 8'hFF, 8'h00, 8'h80);
		send_idle_pct = 48;
		run_random(45);

		set_config(8'($urandom), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
			8'($urandom), 8'($urandom), 8'($urandom));
		send_idle_pct = 0;
		stall_pct = 48;
		run_random(45);

		set_config(8'h80, 8'hFE, 8'hFD, 8'h03, 8'h03, 8'h04);
		send_idle_pct = 31;
		stall_pct = 31;
		run_random(45);

		// Long hold-off on the output while an overflowing frame keeps coming.
		set_config(8'($urandom), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
			8'($urandom), 8'($urandom), 8'($urandom));
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		send_frame(FRAME_BYTES + 7);
		drain();
		send_idle_pct = 20;
		stall_pct = 20;
		run_random(40);

		// Run the idle timer past a short timeout.
		set_config(8'hAA, FRAME_RESET, CONTROL_RESET, POWER_VAR_RESET,
			ENABLE_VAR_RESET, TIMEOUT_VAR_RESET);
		send_idle_pct = 0;
		stall_pct = 0;
		send_control(sb.var_enable, 16'd1, 3);
		send_control(sb.var_timeout, 16'd20, 3);
		send_byte(IDLE_CMD);
		repeat (24) send_tick();

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("led_frame_command_receiver test passed");
		else
			$display("led_frame_command_receiver test failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/lcr_pkg.sv
rtl/lcr_frame_store.sv
rtl/lcr_parser.sv
rtl/led_frame_command_receiver.sv
dv/tb.sv
